// ----- hw/rtl/tbt_pkg.sv -----
// shared widths, register indexes, reset values and limits of the touch baseline tracker
package tbt_pkg;

  localparam int ELEC_W    = 5;
  localparam int SAMPLE_W  = 10;
  localparam int RATE_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int BASE_W    = 26;
  localparam int VALUE_W   = 27;
  localparam int STORE_W   = 28;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;

  typedef logic [ELEC_W-1:0]          elec_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic [RATE_W-1:0]          rate_t;
  typedef logic [BASE_W-1:0]          base_t;
  typedef logic signed [STORE_W-1:0]  store_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_JUMP   = 3'd0;
  localparam cfg_idx_t REG_NEAR   = 3'd1;
  localparam cfg_idx_t REG_FAST   = 3'd2;
  localparam cfg_idx_t REG_SLOW   = 3'd3;
  localparam cfg_idx_t REG_SMOOTH = 3'd4;
  localparam cfg_idx_t REG_SETTLE = 3'd5;

  // reset values
  localparam sample_t RST_JUMP   = 10'd400;
  localparam sample_t RST_NEAR   = 10'd5;
  localparam rate_t   RST_FAST   = 16'd328;
  localparam rate_t   RST_SLOW   = 16'd7;
  localparam rate_t   RST_SMOOTH = 16'd6554;
  localparam base_t   RST_SETTLE = 26'd65536;

  // saturation limits, baseline Q10.16 and touch value Q11.16
  localparam base_t BASE_MAX  = 26'd67043328;
  localparam int    VAL_LIMIT = 67043328;

  // half an lsb of the Q0.16 product, for round to nearest
  localparam int ROUND_HALF = 32768;

endpackage

// ----- hw/rtl/touch_baseline_tracker_top.sv -----
// touch baseline tracker: per-electrode baseline and touch value with pipelined update
//
// usage: one input transaction carries an electrode number and a 10-bit filtered
// capacitance sample; one output transaction per input carries the electrode
// number, the new touch value (signed Q11.16) and the new baseline (Q10.16).
// configuration is written through cfg_write/cfg_index/cfg_data while idle.
// the memories are read at the accepting edge, then baseline multiply, baseline
// update, smoothing multiply and value update into the output register each
// end in a register of their own.
// throughput is one transaction per cycle while the receiver does not stall and
// no sample goes to an electrode whose update is still in the four pipeline
// stages; such a sample is held off by the read/write interlock on the state
// memories until that update has been written back.
// reset clears the configuration to its defaults and clears one valid flag per
// electrode, so every electrode starts from a zero baseline and zero value
// with no clearing pass.
// when the receiver stalls, the output register holds and the stages behind it
// fill up; from that stall, in_stall rises only once the first stage cannot move on.
module touch_baseline_tracker_top #(
  parameter int ELECTRODES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbt_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tbt_pkg::ELEC_W-1:0]       electrode,
  input  logic [tbt_pkg::SAMPLE_W-1:0]     raw_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tbt_pkg::ELEC_W-1:0]       electrode_out,
  output logic signed [tbt_pkg::VALUE_W-1:0] touch_value,
  output logic [tbt_pkg::BASE_W-1:0]       baseline_out
);
  import tbt_pkg::*;

  localparam int SLOT_W   = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
  // reciprocal for electrode modulo ELECTRODES on a 5-bit number
  localparam int RECIP_SH = 10;
  localparam int RECIP    = (1 << RECIP_SH) / ELECTRODES + 1;
  localparam int QE_W     = 14;

  localparam logic signed [30:0] V_HI = 31'(VAL_LIMIT);
  localparam logic signed [30:0] V_LO = -V_HI;

  // configuration registers
  sample_t cfg_jump;
  sample_t cfg_near;
  rate_t   cfg_fast;
  rate_t   cfg_slow;
  rate_t   cfg_smooth;
  base_t   cfg_settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_jump   <= RST_JUMP;
      cfg_near   <= RST_NEAR;
      cfg_fast   <= RST_FAST;
      cfg_slow   <= RST_SLOW;
      cfg_smooth <= RST_SMOOTH;
      cfg_settle <= RST_SETTLE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_JUMP:   cfg_jump   <= cfg_data[SAMPLE_W-1:0];
        REG_NEAR:   cfg_near   <= cfg_data[SAMPLE_W-1:0];
        REG_FAST:   cfg_fast   <= cfg_data[RATE_W-1:0];
        REG_SLOW:   cfg_slow   <= cfg_data[RATE_W-1:0];
        REG_SMOOTH: cfg_smooth <= cfg_data[RATE_W-1:0];
        REG_SETTLE: cfg_settle <= cfg_data[BASE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // electrode to state slot: quotient by reciprocal, then one correction step
  logic [15:0]       quot_prod;
  logic [ELEC_W-1:0] quot;
  logic [QE_W-1:0]   quot_e;
  logic [QE_W-1:0]   rem_raw;
  logic [QE_W-1:0]   rem;
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    quot_prod = 16'(electrode) * 16'(RECIP);
    quot      = quot_prod[RECIP_SH +: ELEC_W];
    quot_e    = QE_W'(quot) * QE_W'(ELECTRODES);
    rem_raw   = QE_W'(electrode) - quot_e;
    if (rem_raw >= QE_W'(ELECTRODES)) begin
      rem = rem_raw - QE_W'(ELECTRODES);
    end else begin
      rem = rem_raw;
    end
    in_slot = SLOT_W'(rem);
  end

  // pipeline control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic en1, en2, en3, en4;
  logic hazard;
  logic accept;

  logic [SLOT_W-1:0] s1_slot, s2_slot, s3_slot, s4_slot;

  assign en4 = !out_valid || !out_stall;
  assign en3 = !s4_valid || en4;
  assign en2 = !s3_valid || en3;
  assign en1 = !s2_valid || en2;

  // interlock: the state of a slot still in flight is not yet written back
  assign hazard = (s1_valid && s1_slot == in_slot) || (s2_valid && s2_slot == in_slot) ||
                  (s3_valid && s3_slot == in_slot) || (s4_valid && s4_slot == in_slot);

  assign in_stall = (s1_valid && !en1) || hazard;
  assign accept   = in_valid && !in_stall;

  // state memories, one entry per electrode, with a valid flag per entry
  base_t  baseline_mem [ELECTRODES];
  store_t value_mem    [ELECTRODES];
  logic   entry_valid  [ELECTRODES];

  base_t  rd_base;
  store_t rd_value;
  logic   rd_ok;

  base_t  b_new;
  store_t v_new;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_base  <= baseline_mem[in_slot];
      rd_value <= value_mem[in_slot];
    end
    if (s4_valid && en4) begin
      baseline_mem[s4_slot] <= b_new;
      value_mem[s4_slot]    <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ELECTRODES; i++) begin
        entry_valid[i] <= 1'b0;
      end
      rd_ok <= 1'b0;
    end else begin
      if (accept) begin
        rd_ok <= entry_valid[in_slot];
      end
      if (s4_valid && en4) begin
        entry_valid[s4_slot] <= 1'b1;
      end
    end
  end

  // stage 1: pick the filter mode and multiply the baseline step
  elec_t   s1_elec;
  sample_t s1_sample;
  base_t   b_old;
  store_t  v_old;
  base_t   s1_s16;
  logic    jump;
  logic    near;
  rate_t   w_base;
  logic signed [BASE_W:0]  delta_b;
  logic signed [43:0]      prod_b;

  always_comb begin
    b_old   = rd_ok ? rd_base : '0;
    v_old   = rd_ok ? rd_value : '0;
    s1_s16  = {s1_sample, {FRAC_W{1'b0}}};
    jump    = ({1'b0, b_old} + {1'b0, cfg_jump, {FRAC_W{1'b0}}}) < {1'b0, s1_s16};
    near    = ({1'b0, s1_s16} + {1'b0, cfg_near, {FRAC_W{1'b0}}}) > {1'b0, b_old};
    w_base  = near ? cfg_fast : cfg_slow;
    delta_b = $signed({1'b0, s1_s16}) - $signed({1'b0, b_old});
    prod_b  = $signed({1'b0, w_base}) * delta_b;
  end

  // stage 2: baseline update, difference and smoothing operand
  elec_t   s2_elec;
  sample_t s2_sample;
  base_t   s2_base;
  store_t  s2_value;
  logic    s2_jump;
  logic signed [43:0] s2_prod;

  base_t s2_s16;
  logic signed [43:0]        prod_b_rnd;
  logic signed [27:0]        adj_b;
  logic signed [28:0]        b_sum;
  base_t                     b_upd;
  logic signed [VALUE_W-1:0] diff;
  logic                      smooth;
  logic signed [28:0]        dv;

  always_comb begin
    s2_s16     = {s2_sample, {FRAC_W{1'b0}}};
    prod_b_rnd = s2_prod + 44'(ROUND_HALF);
    adj_b      = prod_b_rnd[43:FRAC_W];
    b_sum      = $signed({3'b000, s2_base}) + {adj_b[27], adj_b};
    if (s2_jump) begin
      b_upd = s2_s16;
    end else if (b_sum[28]) begin
      b_upd = '0;
    end else if (b_sum > $signed({3'b000, BASE_MAX})) begin
      b_upd = BASE_MAX;
    end else begin
      b_upd = b_sum[BASE_W-1:0];
    end
    diff   = $signed({1'b0, b_upd}) - $signed({1'b0, s2_s16});
    smooth = s2_value < $signed({2'b00, cfg_settle});
    dv     = {{2{diff[VALUE_W-1]}}, diff} - {s2_value[STORE_W-1], s2_value};
  end

  // stage 3: multiply the smoothing step
  elec_t  s3_elec;
  base_t  s3_base;
  logic signed [VALUE_W-1:0] s3_diff;
  store_t s3_value;
  logic   s3_smooth;
  logic signed [28:0] s3_dv;
  logic signed [45:0] prod_v;

  assign prod_v = $signed({1'b0, cfg_smooth}) * s3_dv;

  // stage 4: touch value update
  elec_t  s4_elec;
  base_t  s4_base;
  logic signed [VALUE_W-1:0] s4_diff;
  store_t s4_value;
  logic   s4_smooth;
  logic signed [45:0] s4_prod;

  logic signed [45:0] prod_v_rnd;
  logic signed [29:0] adj_v;
  logic signed [30:0] v_sum;
  logic signed [30:0] v_pick;

  always_comb begin
    prod_v_rnd = s4_prod + 46'(ROUND_HALF);
    adj_v      = prod_v_rnd[45:FRAC_W];
    v_sum      = {{3{s4_value[STORE_W-1]}}, s4_value} + {adj_v[29], adj_v};
    v_pick     = s4_smooth ? v_sum : {{4{s4_diff[VALUE_W-1]}}, s4_diff};
    if (v_pick > V_HI) begin
      v_new = V_HI[STORE_W-1:0];
    end else if (v_pick < V_LO) begin
      v_new = V_LO[STORE_W-1:0];
    end else begin
      v_new = v_pick[STORE_W-1:0];
    end
    b_new = s4_base;
  end

  // valid flags of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s1_valid || en1) begin
        s1_valid <= accept;
      end
      if (en1) begin
        s2_valid <= s1_valid;
      end
      if (en2) begin
        s3_valid <= s2_valid;
      end
      if (en3) begin
        s4_valid <= s3_valid;
      end
      if (en4) begin
        out_valid <= s4_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_elec   <= electrode;
      s1_sample <= raw_sample;
      s1_slot   <= in_slot;
    end
    if (en1 && s1_valid) begin
      s2_elec   <= s1_elec;
      s2_sample <= s1_sample;
      s2_slot   <= s1_slot;
      s2_base   <= b_old;
      s2_value  <= v_old;
      s2_jump   <= jump;
      s2_prod   <= prod_b;
    end
    if (en2 && s2_valid) begin
      s3_elec   <= s2_elec;
      s3_slot   <= s2_slot;
      s3_base   <= b_upd;
      s3_diff   <= diff;
      s3_value  <= s2_value;
      s3_smooth <= smooth;
      s3_dv     <= dv;
    end
    if (en3 && s3_valid) begin
      s4_elec   <= s3_elec;
      s4_slot   <= s3_slot;
      s4_base   <= s3_base;
      s4_diff   <= s3_diff;
      s4_value  <= s3_value;
      s4_smooth <= s3_smooth;
      s4_prod   <= prod_v;
    end
    if (en4 && s4_valid) begin
      electrode_out <= s4_elec;
      touch_value   <= v_new[VALUE_W-1:0];
      baseline_out  <= b_new;
    end
  end

endmodule
